// ===== rtl/scs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants for the serial command display unit
// Word layouts of both channels, command codes, seven-segment table and the
// small helpers used by the decode and pattern logic.
// ----------------------------------------------------------------------------
package scs_pkg;

	// Character codes
	localparam logic [7:0] CR_CHAR    = 8'd13;
	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_ONE  = 8'h31;
	localparam logic [7:0] ASCII_TWO  = 8'h32;
	localparam logic [7:0] CMD_ADC    = 8'h41;   // 'A'
	localparam logic [7:0] CMD_COPY   = 8'h43;   // 'C'

	localparam logic [3:0] BLANK_DIGIT = 4'd15;

	// Buffer positions that are kept
	localparam int POS_LETTER  = 0;
	localparam int POS_CHANNEL = 1;
	localparam int POS_DIGIT0  = 4;
	localparam int POS_DIGIT3  = 7;

	// Input word: one received character plus the current converter samples
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [9:0] adc_chan0;
		logic [9:0] adc_chan1;
	} cmd_word_t;

	// Output word: one display position
	typedef struct packed {
		logic [6:0] seg_pattern;
		logic [1:0] digit_index;
		logic       last;
	} disp_word_t;

	// Kept positions of the command buffer
	typedef struct packed {
		logic [7:0]      letter;
		logic [7:0]      chan_char;
		logic [3:0][7:0] digit_chars;
	} cmd_buf_t;

	// Display state handed between decode and top level
	typedef struct packed {
		logic [3:0][3:0] digits;
		logic            channel;
	} disp_state_t;

	// ASCII digit to value, anything else goes blank
	function automatic logic [3:0] char_to_digit(input logic [7:0] ch);
		logic [7:0] v;
		v = ch - ASCII_ZERO;
		return (v <= 8'd9) ? v[3:0] : BLANK_DIGIT;
	endfunction

	// Segment bits gfedcba; values above nine show blank
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'b0111111;
			4'd1: s = 7'b0000110;
			4'd2: s = 7'b1011011;
			4'd3: s = 7'b1001111;
			4'd4: s = 7'b1100110;
			4'd5: s = 7'b1101101;
			4'd6: s = 7'b1111101;
			4'd7: s = 7'b0000111;
			4'd8: s = 7'b1111111;
			4'd9: s = 7'b1101111;
			default: s = 7'b0000000;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/scs_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_stream_if: valid/ready channel
// One word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface scs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/scs_digit_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_digit_decode: command decode
// Works out the next displayed digits and channel from a finished command
// and the converter samples that came with its carriage return.
// ----------------------------------------------------------------------------
module scs_digit_decode import scs_pkg::*; (
	input  cmd_buf_t    cmd_buf,
	input  logic [9:0]  adc_chan0,
	input  logic [9:0]  adc_chan1,
	input  disp_state_t cur,
	output disp_state_t nxt
);

	logic        chan;
	logic [9:0]  sample;
	logic        thou;
	logic [9:0]  rem_h;
	logic [15:0] prod_h;
	logic [3:0]  hund;
	logic [6:0]  rem_t;
	logic [14:0] prod_t;
	logic [3:0]  tens;
	logic [3:0]  units;

	// Channel pick: '1' and '2' select, anything else keeps the old one
	always_comb begin
		chan = cur.channel;
		if (cmd_buf.chan_char == ASCII_ONE) begin
			chan = 1'b0;
		end else if (cmd_buf.chan_char == ASCII_TWO) begin
			chan = 1'b1;
		end
	end

	// Decimal split by reciprocal multiplies, exact for samples below 1024
	always_comb begin
		sample = chan ? adc_chan1 : adc_chan0;
		thou   = (sample >= 10'd1000);
		rem_h  = thou ? (sample - 10'd1000) : sample;
		prod_h = 16'(rem_h) * 16'd41;          // /100 as *41 >> 12
		hund   = prod_h[15:12];
		rem_t  = 7'(rem_h - 10'(hund) * 10'd100);
		prod_t = 15'(rem_t) * 15'd205;         // /10 as *205 >> 11
		tens   = prod_t[14:11];
		units  = 4'(rem_t - 7'(tens) * 7'd10);
	end

	always_comb begin
		nxt = cur;
		case (cmd_buf.letter)
			CMD_COPY: begin
				for (int k = 0; k < 4; k++) begin
					nxt.digits[k] = char_to_digit(cmd_buf.digit_chars[k]);
				end
			end
			CMD_ADC: begin
				nxt.channel   = chan;
				nxt.digits[0] = {3'b000, thou};
				nxt.digits[1] = hund;
				nxt.digits[2] = tens;
				nxt.digits[3] = units;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== rtl/serial_command_to_seven_segment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_to_seven_segment_unit: serial commands to display patterns
// Collects received characters into a command and refreshes a four digit
// seven-segment display on every carriage return.
// ----------------------------------------------------------------------------
// Use:
//   cmd  - input words: one received character with the two converter
//          samples current at that moment. Any character but carriage
//          return is stored; bytes past MAX_CMD_BYTES are dropped.
//   disp - output words: four patterns per carriage return, positions
//          3, 2, 1, 0, with last set on position 0.
// Order: a taken carriage return passes the input register, then loads the
//   pattern registers, which put the first pattern of its refresh out.
// Throughput: one character a cycle while no carriage return waits in the
//   input register. A refresh holds the four-entry pattern shift register
//   until its last pattern is taken; a following carriage return waits in
//   the input register until the last pattern of the previous refresh leaves.
// Reset: buffer and count cleared, display shows 0000, channel zero, no
//   word pending on either side.
// Stall: a stalled receiver holds the current pattern; plain characters
//   keep flowing, a carriage return waits and then blocks cmd.
// ----------------------------------------------------------------------------
module serial_command_to_seven_segment_unit import scs_pkg::*; #(
	parameter int MAX_CMD_BYTES = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	scs_stream_if.sink         cmd,
	scs_stream_if.source       disp
);

	localparam int CNT_W = $clog2(MAX_CMD_BYTES + 1);

	// Input register
	logic        valid_s1;
	cmd_word_t   word_s1;

	// Command and display state
	logic [CNT_W-1:0] count_q;
	cmd_buf_t         buf_q;
	disp_state_t      state_q;
	disp_state_t      state_nxt;

	// Pattern shift register, entry 0 is on the output
	logic [6:0]  pat_q [4];
	logic        busy_q;
	logic [1:0]  idx_q;

	logic is_cr;
	logic out_take;
	logic out_free;
	logic adv_s1;
	logic load;

	assign is_cr    = (word_s1.rx_byte == CR_CHAR);
	assign out_take = busy_q && disp.ready;
	assign out_free = !busy_q || (disp.ready && (idx_q == 2'd0));
	assign adv_s1   = valid_s1 && (!is_cr || out_free);
	assign load     = adv_s1 && is_cr;

	assign cmd.ready = !valid_s1 || adv_s1;

	assign disp.valid            = busy_q;
	assign disp.data.seg_pattern = pat_q[0];
	assign disp.data.digit_index = idx_q;
	assign disp.data.last        = (idx_q == 2'd0);

	scs_digit_decode u_decode (
		.cmd_buf   (buf_q),
		.adc_chan0 (word_s1.adc_chan0),
		.adc_chan1 (word_s1.adc_chan1),
		.cur       (state_q),
		.nxt       (state_nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			word_s1 <= cmd.data;
		end
	end

	// Command buffer, count and display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			buf_q   <= '0;
			state_q <= '0;
		end else if (load) begin
			count_q <= '0;
			buf_q   <= '0;
			state_q <= state_nxt;
		end else if (adv_s1 && (count_q < CNT_W'(MAX_CMD_BYTES))) begin
			count_q <= count_q + 1'b1;
			if (count_q == CNT_W'(POS_LETTER)) begin
				buf_q.letter <= word_s1.rx_byte;
			end else if (count_q == CNT_W'(POS_CHANNEL)) begin
				buf_q.chan_char <= word_s1.rx_byte;
			end else if ((count_q >= CNT_W'(POS_DIGIT0)) &&
			             (count_q <= CNT_W'(POS_DIGIT3))) begin
				buf_q.digit_chars[count_q[1:0]] <= word_s1.rx_byte;
			end
		end
	end

	// Output control: count positions 3 down to 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd3;
		end else if (out_take) begin
			if (idx_q == 2'd0) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q - 2'd1;
		end
	end

	// Pattern registers: load position 3 first, shift on each taken word
	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < 4; k++) begin
				pat_q[k] <= seg_of(state_nxt.digits[3 - k]);
			end
		end else if (out_take) begin
			pat_q[0] <= pat_q[1];
			pat_q[1] <= pat_q[2];
			pat_q[2] <= pat_q[3];
		end
	end

endmodule

// ===== rtl/scs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_checker: port checks for the serial command display unit
// Watches the display channel for refresh ordering and stall behaviour.
// ----------------------------------------------------------------------------
module scs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       disp_valid,
	input logic       disp_ready,
	input logic [6:0] seg_pattern,
	input logic [1:0] digit_index,
	input logic       last
);

	// last marks position 0 and nothing else
	assert property (@(posedge clk) disp_valid |-> (last == (digit_index == 2'd0)))
		else $error("last flag does not match position 0");

	// a refresh runs down without gaps: next word is the next lower position
	assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && disp_ready && (digit_index != 2'd0)) |=>
		(disp_valid && (digit_index == $past(digit_index) - 2'd1)))
		else $error("refresh word missing or out of order");

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid && !disp_ready) |=>
		(disp_valid && $stable(seg_pattern) && $stable(digit_index)))
		else $error("stalled display word changed");

endmodule

bind serial_command_to_seven_segment_unit scs_checker u_scs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.disp_valid  (disp.valid),
	.disp_ready  (disp.ready),
	.seg_pattern (disp.data.seg_pattern),
	.digit_index (disp.data.digit_index),
	.last        (disp.data.last)
);

// ===== dv/tb_serial_command_to_seven_segment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_command_to_seven_segment_unit: display refresh checker
// Feeds serial characters with converter samples into the command channel.
// An in-bench model of the command buffer and display predicts the four
// patterns of every carriage return, and the monitor checks each word that
// leaves the display channel. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_serial_command_to_seven_segment_unit;
	import scs_pkg::*;

	localparam int CMD_DEPTH    = 14;
	localparam int NUM_ITEMS    = 110;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int IDLE_PCT     = 31;
	localparam int TAIL_CYCLES  = 8;

	// Segment bits gfedcba for values 0..15, value 0 in the low seven bits
	localparam logic [16*7-1:0] SEG_LUT = {
		42'd0,
		7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	logic clk;
	logic arst_n;

	scs_stream_if #(.payload_t(cmd_word_t))  cmd_if ();
	scs_stream_if #(.payload_t(disp_word_t)) disp_if ();

	serial_command_to_seven_segment_unit #(
		.MAX_CMD_BYTES(CMD_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if.sink),
		.disp  (disp_if.source)
	);

	// Words waiting to be driven, and patterns waiting to be seen
	cmd_word_t  char_pending[$];
	disp_word_t pattern_q[$];
	cmd_word_t  next_word;

	int  pushed_cnt;
	int  taken_cnt;
	int  err_cnt;
	int  cycle_cnt;
	bit  char_taken;

	// Model of the command buffer and the display
	int         cmd_len;
	logic [7:0] buf_letter;
	logic [7:0] buf_chan;
	logic [7:0] buf_digits [4];
	logic [3:0] lit_digits [4];
	logic       sel_chan;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// No idling while the middle of the random part goes through
	function automatic bit take_break();
		if (taken_cnt >= 60 && taken_cnt < 100)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		err_cnt++;
	endtask

	// Buffer one character; on carriage return decode and queue four patterns
	task automatic predict_display(input cmd_word_t w);
		disp_word_t pat;
		int         sample;
		int         k;
		if (w.rx_byte != CR_CHAR) begin
			if (cmd_len < CMD_DEPTH) begin
				if (cmd_len == POS_LETTER)
					buf_letter = w.rx_byte;
				else if (cmd_len == POS_CHANNEL)
					buf_chan = w.rx_byte;
				else if (cmd_len >= POS_DIGIT0 && cmd_len <= POS_DIGIT3)
					buf_digits[cmd_len - POS_DIGIT0] = w.rx_byte;
				cmd_len++;
			end
		end else begin
			if (buf_letter == CMD_COPY) begin
				for (k = 0; k < 4; k++) begin
					if (buf_digits[k] >= ASCII_ZERO && buf_digits[k] <= ASCII_ZERO + 8'd9)
						lit_digits[k] = 4'(buf_digits[k] - ASCII_ZERO);
					else
						lit_digits[k] = BLANK_DIGIT;
				end
			end else if (buf_letter == CMD_ADC) begin
				if (buf_chan == ASCII_ONE)
					sel_chan = 1'b0;
				else if (buf_chan == ASCII_TWO)
					sel_chan = 1'b1;
				sample = sel_chan ? int'(w.adc_chan1) : int'(w.adc_chan0);
				lit_digits[0] = 4'((sample / 1000) % 10);
				lit_digits[1] = 4'((sample / 100) % 10);
				lit_digits[2] = 4'((sample / 10) % 10);
				lit_digits[3] = 4'(sample % 10);
			end
			cmd_len    = 0;
			buf_letter = '0;
			buf_chan   = '0;
			for (k = 0; k < 4; k++)
				buf_digits[k] = '0;
			// most significant position first
			for (k = 3; k >= 0; k--) begin
				pat.seg_pattern = SEG_LUT[lit_digits[k] * 7 +: 7];
				pat.digit_index = 2'(k);
				pat.last        = (k == 0);
				pattern_q.push_back(pat);
			end
		end
	endtask

	task automatic push_word(input logic [7:0] ch, input logic [9:0] a0,
			input logic [9:0] a1);
		cmd_word_t w;
		w.rx_byte   = ch;
		w.adc_chan0 = a0;
		w.adc_chan1 = a1;
		char_pending.push_back(w);
		pushed_cnt++;
	endtask

	task automatic push_char(input logic [7:0] ch);
		push_word(ch, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
	endtask

	// Sample with a fair share of the extremes
	function automatic logic [9:0] pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return 10'd0;
		if (roll < 16)
			return 10'd1023;
		return 10'($urandom_range(1023));
	endfunction

	function automatic logic [7:0] pick_plain();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CR_CHAR)
			b = b ^ 8'h80;
		return b;
	endfunction

	task automatic wait_drained();
		while (char_pending.size() != 0 || taken_cnt != pushed_cnt || pattern_q.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus, then end of test
	initial begin
		int         kind;
		int         len;
		int         p;
		int         goal;
		logic [7:0] b;
		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.data     = '0;
		disp_if.ready   = 1'b0;
		pushed_cnt      = 0;
		taken_cnt       = 0;
		err_cnt         = 0;
		cycle_cnt       = 0;
		char_taken      = 1'b0;
		cmd_len         = 0;
		buf_letter      = '0;
		buf_chan        = '0;
		sel_chan        = 1'b0;
		for (p = 0; p < 4; p++) begin
			buf_digits[p] = '0;
			lit_digits[p] = '0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty command straight after reset: display keeps 0000
		push_word(CR_CHAR, 10'd1023, 10'd1023);
		// channel zero at full scale
		push_char(CMD_ADC);
		push_char(ASCII_ONE);
		push_word(CR_CHAR, 10'd1023, 10'd0);
		// channel one at zero
		push_char(CMD_ADC);
		push_char(ASCII_TWO);
		push_word(CR_CHAR, 10'd1023, 10'd0);
		// no channel character keeps channel one
		push_char(CMD_ADC);
		push_word(CR_CHAR, 10'd512, 10'd1000);
		// copy command with non-digits either side of the digit range,
		// filled to the end of the buffer and one character beyond it
		push_char(CMD_COPY);
		push_char(8'hFF);
		push_char(8'h00);
		push_char(8'h80);
		push_char(ASCII_ZERO + 8'd9);
		push_char(ASCII_ZERO + 8'd10);
		push_char(ASCII_ZERO);
		push_char(ASCII_ZERO - 8'd1);
		push_char(ASCII_ZERO + 8'd7);
		push_char(8'h7F);
		push_char(ASCII_ZERO + 8'd1);
		push_char(ASCII_ZERO + 8'd2);
		push_char(ASCII_ZERO + 8'd3);
		push_char(ASCII_ZERO + 8'd4);
		push_char(ASCII_ZERO + 8'd5);
		push_word(CR_CHAR, pick_sample(), pick_sample());

		// hold the sender until the display has caught up
		wait_drained();

		// random commands up to the word count, draining once half way
		goal = pushed_cnt + (NUM_ITEMS - pushed_cnt) / 2;
		while (pushed_cnt < NUM_ITEMS) begin
			if (goal != 0 && pushed_cnt >= goal) begin
				wait_drained();
				goal = 0;
			end
			kind = $urandom_range(99);
			if (kind < 35) begin
				// copy command, mostly eight characters of which four digits
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : 8;
				push_char(CMD_COPY);
				for (p = 1; p < len; p++) begin
					if (p >= POS_DIGIT0 && p <= POS_DIGIT3 && $urandom_range(9) != 0)
						push_char(ASCII_ZERO + 8'($urandom_range(9)));
					else
						push_char(pick_plain());
				end
			end else if (kind < 70) begin
				// converter command
				push_char(CMD_ADC);
				p = $urandom_range(9);
				if (p < 4)
					push_char(ASCII_ONE);
				else if (p < 8)
					push_char(ASCII_TWO);
				else if (p == 8)
					push_char(pick_plain());
				len = $urandom_range(3) == 0 ? $urandom_range(1, 4) : 0;
				for (p = 0; p < len; p++)
					push_char(pick_plain());
			end else if (kind < 85) begin
				// noise, carriage returns may fall anywhere
				len = $urandom_range(16);
				for (p = 0; p < len; p++)
					push_char(8'($urandom_range(255)));
			end else begin
				// some other command letter
				b = pick_plain();
				if (b == CMD_ADC || b == CMD_COPY)
					b = b ^ 8'h20;
				push_char(b);
				len = $urandom_range(5);
				for (p = 0; p < len; p++)
					push_char(pick_plain());
			end
			push_word(CR_CHAR, pick_sample(), pick_sample());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Acceptance of command words feeds the model
	always @(posedge clk) begin
		char_taken = 1'b0;
		if (arst_n && cmd_if.valid && cmd_if.ready) begin
			char_taken = 1'b1;
			predict_display(cmd_if.data);
			taken_cnt++;
		end
	end

	// Command driver: a word stays on the channel until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_if.valid || char_taken) begin
				if (char_pending.size() > 0 && !take_break()) begin
					next_word = char_pending.pop_front();
					cmd_if.data  <= next_word;
					cmd_if.valid <= 1'b1;
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
			disp_if.ready <= !take_break();
		end
	end

	// Display monitor
	always @(posedge clk) begin
		disp_word_t got;
		disp_word_t want;
		if (arst_n && disp_if.valid && disp_if.ready) begin
			got = disp_if.data;
			if (pattern_q.size() == 0) begin
				report_mismatch("unexpected pattern word", int'(got), -1);
			end else begin
				want = pattern_q.pop_front();
				if (got.seg_pattern != want.seg_pattern)
					report_mismatch("seg_pattern", got.seg_pattern, want.seg_pattern);
				if (got.digit_index != want.digit_index)
					report_mismatch("digit_index", got.digit_index, want.digit_index);
				if (got.last != want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/scs_pkg.sv
rtl/scs_stream_if.sv
rtl/scs_digit_decode.sv
rtl/serial_command_to_seven_segment_unit.sv
rtl/scs_checker.sv
dv/tb_serial_command_to_seven_segment_unit.sv
